@@ rtl/core/phpc_pkg.sv @@
// Package for the packet header parser with checksum verify.
// Holds the result beat type, status and kind codes, and the ones' complement add.
// No dependencies.
`default_nettype none

package phpc_pkg;

    localparam int unsigned HDR_BYTES  = 14;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int unsigned TDATA_W    = 112;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SUM = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [7:0]         payload_byte;
        logic [31:0]        source_address;
        logic [31:0]        dest_address;
        logic signed [15:0] sequence_number;
        logic [15:0]        length_bits;
        logic [1:0]         status;
        logic               end_of_run;
    } result_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/phpc_parse.sv @@
// Header capture, payload pass-through and running checksum for one byte per cycle while in_accept is high.
// Produces up to two result beats per accepted byte. Depends on phpc_pkg.
`default_nettype none

module phpc_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              end_of_packet,
    output phpc_pkg::result_t      res_a,
    output phpc_pkg::result_t      res_b,
    output logic [1:0]             res_cnt
);
    import phpc_pkg::*;

    logic [15:0] count_reg, count_next, count_upd;
    logic [15:0] sum_reg, sum_next, sum_upd;
    logic [7:0]  pend_reg, pend_next, pend_upd;
    logic [31:0] src_reg, src_next, src_upd;
    logic [31:0] dst_reg, dst_next, dst_upd;
    logic [15:0] seq_reg, seq_next, seq_upd;
    logic [15:0] csum_reg, csum_next, csum_upd;
    logic [15:0] len_reg, len_next, len_upd;

    logic [15:0] limit_cur, limit_upd, final_sum;
    logic [7:0]  v, mask;
    logic [1:0]  status;
    logic        in_pkt;
    result_t     pay_res, sum_res;

    assign limit_cur = 16'(HDR_BYTES) + 16'((17'(len_reg) + 17'd7) >> 3);
    assign limit_upd = 16'(HDR_BYTES) + 16'((17'(len_upd) + 17'd7) >> 3);
    assign in_pkt    = count_reg < limit_cur;
    assign mask      = ~(8'hFF >> len_reg[2:0]);

    always_comb begin
        src_upd  = src_reg;
        dst_upd  = dst_reg;
        seq_upd  = seq_reg;
        csum_upd = csum_reg;
        len_upd  = len_reg;
        v        = rx_byte;
        if (in_pkt && count_reg < 16'(HDR_BYTES)) begin
            case (count_reg[3:0])
                4'd0:    src_upd[31:24] = rx_byte;
                4'd1:    src_upd[23:16] = rx_byte;
                4'd2:    src_upd[15:8]  = rx_byte;
                4'd3:    src_upd[7:0]   = rx_byte;
                4'd4:    dst_upd[31:24] = rx_byte;
                4'd5:    dst_upd[23:16] = rx_byte;
                4'd6:    dst_upd[15:8]  = rx_byte;
                4'd7:    dst_upd[7:0]   = rx_byte;
                4'd8:    seq_upd[15:8]  = rx_byte;
                4'd9:    seq_upd[7:0]   = rx_byte;
                4'd10: begin
                    csum_upd[15:8] = rx_byte;
                    v              = 8'd0;
                end
                4'd11: begin
                    csum_upd[7:0] = rx_byte;
                    v             = 8'd0;
                end
                4'd12:   len_upd[15:8]  = rx_byte;
                default: len_upd[7:0]   = rx_byte;
            endcase
        end else if (in_pkt && count_reg == limit_cur - 16'd1 && len_reg[2:0] != 3'd0) begin
            v = rx_byte & mask;
        end
    end

    always_comb begin
        count_upd = count_reg;
        sum_upd   = sum_reg;
        pend_upd  = pend_reg;
        if (in_pkt) begin
            count_upd = count_reg + 16'd1;
            if (!count_reg[0]) begin
                pend_upd = v;
            end else begin
                sum_upd = ones_add(sum_reg, {pend_reg, v});
            end
        end
    end

    assign final_sum = count_upd[0] ? ones_add(sum_upd, {pend_upd, 8'd0}) : sum_upd;

    always_comb begin
        if (count_upd < 16'(HDR_BYTES) || count_upd < limit_upd) begin
            status = ST_TRUNC;
        end else if (~final_sum == csum_upd) begin
            status = ST_OK;
        end else begin
            status = ST_BAD_SUM;
        end
    end

    always_comb begin
        pay_res              = '0;
        pay_res.kind         = KIND_PAYLOAD;
        pay_res.payload_byte = v;
        pay_res.end_of_run   = !end_of_packet;

        sum_res                 = '0;
        sum_res.kind            = KIND_SUMMARY;
        sum_res.source_address  = src_upd;
        sum_res.dest_address    = dst_upd;
        sum_res.sequence_number = seq_upd;
        sum_res.length_bits     = len_upd;
        sum_res.status          = status;
        sum_res.end_of_run      = 1'b1;
    end

    always_comb begin
        res_a   = sum_res;
        res_b   = sum_res;
        res_cnt = 2'd0;
        if (in_accept) begin
            if (in_pkt && count_reg >= 16'(HDR_BYTES)) begin
                res_a   = pay_res;
                res_cnt = end_of_packet ? 2'd2 : 2'd1;
            end else if (end_of_packet) begin
                res_cnt = 2'd1;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        seq_next   = seq_reg;
        csum_next  = csum_reg;
        len_next   = len_reg;
        if (in_accept) begin
            if (end_of_packet) begin
                count_next = '0;
                sum_next   = '0;
                pend_next  = '0;
                src_next   = '0;
                dst_next   = '0;
                seq_next   = '0;
                csum_next  = '0;
                len_next   = '0;
            end else begin
                count_next = count_upd;
                sum_next   = sum_upd;
                pend_next  = pend_upd;
                src_next   = src_upd;
                dst_next   = dst_upd;
                seq_next   = seq_upd;
                csum_next  = csum_upd;
                len_next   = len_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            pend_reg  <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            seq_reg   <= '0;
            csum_reg  <= '0;
            len_reg   <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            pend_reg  <= pend_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            seq_reg   <= seq_next;
            csum_reg  <= csum_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/phpc_out_queue.sv @@
// Small result queue that takes up to two beats per cycle and gives one per cycle on pop.
// Depends on phpc_pkg.
`default_nettype none

module phpc_out_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  phpc_pkg::result_t      push_a,
    input  phpc_pkg::result_t      push_b,
    input  wire logic [1:0]        push_cnt,
    output logic                   space2,
    output phpc_pkg::result_t      head,
    output logic                   head_valid,
    input  wire logic              pop
);
    import phpc_pkg::*;

    result_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_b;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;
    logic                 do_pop;

    assign head_valid  = count_reg != '0;
    assign head        = entry_reg[rd_ptr_reg];
    assign do_pop      = pop && head_valid;
    assign space2      = count_reg <= (Q_PTR_W+1)'(Q_DEPTH - 2);
    assign wr_ptr_b    = wr_ptr_reg + Q_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + Q_PTR_W'(do_pop);
    assign count_next  = count_reg + (Q_PTR_W+1)'(push_cnt) - (Q_PTR_W+1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_b] <= push_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/packet_header_parse_checksum_top.sv @@
// Top level of the packet header parser with ones' complement checksum verify.
// A result beat is registered in the result queue before it is offered on m_tdata.
// Throughput: one byte beat per cycle; a last byte that is a payload byte gives
// two result beats, and s_tready falls while the four-entry result queue holds three or more.
// Reset (aresetn low, synchronous) clears the parser state and empties the result queue.
// Depends on phpc_pkg, phpc_parse and phpc_out_queue.
`default_nettype none

module packet_header_parse_checksum_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tlast,   // end_of_packet
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [phpc_pkg::TDATA_W-1:0] m_tdata,
    // m_tdata from bit 0: payload_byte, source_address, dest_address,
    // sequence_number, length_bits, status, then zero fill.
    output logic             m_tuser,   // kind
    output logic             m_tlast    // end_of_run
);
    import phpc_pkg::*;

    result_t    res_a, res_b, head;
    logic [1:0] res_cnt;
    logic       space2, in_accept;

    assign s_tready  = space2;
    assign in_accept = s_tvalid && s_tready;

    phpc_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .rx_byte       (s_tdata),
        .end_of_packet (s_tlast),
        .res_a         (res_a),
        .res_b         (res_b),
        .res_cnt       (res_cnt)
    );

    phpc_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_a     (res_a),
        .push_b     (res_b),
        .push_cnt   (res_cnt),
        .space2     (space2),
        .head       (head),
        .head_valid (m_tvalid),
        .pop        (m_tready)
    );

    assign m_tdata = {6'd0, head.status, head.length_bits, head.sequence_number,
                      head.dest_address, head.source_address, head.payload_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.end_of_run;

endmodule

`default_nettype wire
